// ----- rtl/mva_pkg.sv -----
// Shared types, message codes and the cutoff table of the MIDI voice allocator.
package mva_pkg;

    localparam int VOICES_DEFAULT = 8;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0] MSG_TYPE_MASK = 8'hF0;
    localparam logic [7:0] MSG_NOTE_ON   = 8'h90;
    localparam logic [7:0] MSG_NOTE_OFF  = 8'h80;
    localparam logic [7:0] MSG_CTRL      = 8'hB0;
    localparam logic [6:0] CTRL_CUTOFF   = 7'h02;

    localparam int CUTOFF_BASE = 200;
    localparam int CUTOFF_SPAN = 9000;
    localparam int CTRL_MAX    = 127;

    localparam logic [2:0] ACT_IGNORED  = 3'd0;
    localparam logic [2:0] ACT_START    = 3'd1;
    localparam logic [2:0] ACT_RELEASE  = 3'd2;
    localparam logic [2:0] ACT_CUTOFF   = 3'd3;
    localparam logic [2:0] ACT_NO_VOICE = 3'd4;
    localparam logic [2:0] ACT_PLAYING  = 3'd5;

    localparam logic [1:0] OP_IGNORE   = 2'd0;
    localparam logic [1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [1:0] OP_NOTE_OFF = 2'd2;
    localparam logic [1:0] OP_CUTOFF   = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [6:0]  note;
        logic [13:0] cutoff;
    } req_t;

    typedef logic [127:0][13:0] cutoff_lut_t;

    function automatic cutoff_lut_t build_cutoff_lut();
        cutoff_lut_t lut;
        for (int i = 0; i < 128; i++) begin
            lut[i] = 14'(CUTOFF_BASE + (i * CUTOFF_SPAN) / CTRL_MAX);
        end
        return lut;
    endfunction

    localparam cutoff_lut_t CUTOFF_LUT = build_cutoff_lut();

endpackage

// ----- rtl/mva_front.sv -----
// Input side: decodes each MIDI message into a queued request.
module mva_front (
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_status_byte,
    input  logic [6:0]    s_note_number,
    input  logic [6:0]    s_velocity,
    input  logic          q_full,
    output logic          q_push,
    output mva_pkg::req_t q_req
);
    import mva_pkg::*;

    logic [7:0] msg_kind;

    assign msg_kind = s_status_byte & MSG_TYPE_MASK;
    assign s_ready  = !q_full;
    assign q_push   = s_valid && !q_full;

    always_comb begin
        q_req.note   = s_note_number;
        q_req.cutoff = CUTOFF_LUT[s_velocity];
        // A Note On with zero velocity is a Note Off by convention.
        if (msg_kind == MSG_NOTE_ON && s_velocity != 7'd0) begin
            q_req.op = OP_NOTE_ON;
        end else if (msg_kind == MSG_NOTE_ON || msg_kind == MSG_NOTE_OFF) begin
            q_req.op = OP_NOTE_OFF;
        end else if (msg_kind == MSG_CTRL && s_note_number == CTRL_CUTOFF) begin
            q_req.op = OP_CUTOFF;
        end else begin
            q_req.op = OP_IGNORE;
        end
    end

endmodule

// ----- rtl/mva_fifo.sv -----
// Short request queue between the decoder and the voice table.
module mva_fifo #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic             full
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][WIDTH-1:0] mem_reg;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign empty   = (count_reg == CW'(0));
    assign full    = (count_reg == CW'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? AW'(0) : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? AW'(0) : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/mva_back.sv -----
// Voice table: carries out queued requests and holds the result register.
module mva_back #(
    parameter int VOICES = mva_pkg::VOICES_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  mva_pkg::req_t q_req,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [2:0]    m_action,
    output logic [4:0]    m_voice_index,
    output logic [6:0]    m_voice_note,
    output logic [13:0]   m_cutoff_hz
);
    import mva_pkg::*;

    logic [VOICES-1:0]      voice_busy_reg, voice_busy_next;
    logic [VOICES-1:0][6:0] voice_notes_reg, voice_notes_next;

    logic [VOICES-1:0] match_vec, free_vec, match_oh, free_oh;
    logic [4:0]        match_idx, free_idx;

    logic        m_valid_reg;
    logic [2:0]  action_reg, action_next;
    logic [4:0]  index_reg, index_next;
    logic [6:0]  note_reg, note_next;
    logic [13:0] cutoff_reg, cutoff_next;

    assign q_pop = !q_empty && (!m_valid_reg || m_ready);

    always_comb begin
        for (int i = 0; i < VOICES; i++) begin
            match_vec[i] = voice_busy_reg[i] && (voice_notes_reg[i] == q_req.note);
            free_vec[i]  = !voice_busy_reg[i];
        end
        // Isolate the lowest set bit to pick the lowest-numbered voice.
        match_oh  = match_vec & (~match_vec + VOICES'(1));
        free_oh   = free_vec & (~free_vec + VOICES'(1));
        match_idx = '0;
        free_idx  = '0;
        for (int i = 0; i < VOICES; i++) begin
            if (match_oh[i]) begin
                match_idx = match_idx | 5'(i);
            end
            if (free_oh[i]) begin
                free_idx = free_idx | 5'(i);
            end
        end
    end

    always_comb begin
        voice_busy_next  = voice_busy_reg;
        voice_notes_next = voice_notes_reg;
        action_next      = ACT_IGNORED;
        index_next       = '0;
        note_next        = '0;
        cutoff_next      = '0;
        unique case (q_req.op)
            OP_NOTE_ON: begin
                if (|match_vec) begin
                    action_next = ACT_PLAYING;
                end else if (|free_vec) begin
                    action_next     = ACT_START;
                    index_next      = free_idx;
                    note_next       = q_req.note;
                    voice_busy_next = voice_busy_reg | free_oh;
                    for (int i = 0; i < VOICES; i++) begin
                        if (free_oh[i]) begin
                            voice_notes_next[i] = q_req.note;
                        end
                    end
                end else begin
                    action_next = ACT_NO_VOICE;
                end
            end
            OP_NOTE_OFF: begin
                if (|match_vec) begin
                    action_next     = ACT_RELEASE;
                    index_next      = match_idx;
                    note_next       = q_req.note;
                    voice_busy_next = voice_busy_reg & ~match_oh;
                end
            end
            OP_CUTOFF: begin
                action_next = ACT_CUTOFF;
                cutoff_next = q_req.cutoff;
            end
            OP_IGNORE: begin
                action_next = ACT_IGNORED;
            end
            default: begin
                action_next = ACT_IGNORED;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            voice_busy_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (q_pop) begin
                voice_busy_reg <= voice_busy_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Notes reset to zero; a free voice's note is never read for a match.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            voice_notes_reg <= '0;
        end else if (q_pop) begin
            voice_notes_reg <= voice_notes_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            action_reg <= action_next;
            index_reg  <= index_next;
            note_reg   <= note_next;
            cutoff_reg <= cutoff_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_action      = action_reg;
    assign m_voice_index = index_reg;
    assign m_voice_note  = note_reg;
    assign m_cutoff_hz   = cutoff_reg;

    a_start_claims_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && action_next == ACT_START) |=>
        ($countones(voice_busy_reg) == $countones($past(voice_busy_reg)) + 1))
        else $error("start did not claim exactly one voice");

    a_release_frees_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && action_next == ACT_RELEASE) |=>
        ($countones(voice_busy_reg) + 1 == $countones($past(voice_busy_reg))))
        else $error("release did not free exactly one voice");

    a_other_keeps_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && action_next != ACT_START && action_next != ACT_RELEASE) |=>
        $stable(voice_busy_reg))
        else $error("busy flags changed without start or release");

    a_no_voice_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && action_next == ACT_NO_VOICE) |-> (&voice_busy_reg))
        else $error("no free voice reported while a voice is free");

endmodule

// ----- rtl/midi_voice_allocator.sv -----
// Top level of the MIDI voice allocator: decoder, request queue and voice table.
//
// Usage:
//   The s_ channel takes one three-byte MIDI message per request (status,
//   note or controller number, velocity or controller value); the channel
//   nibble is ignored. The m_ channel returns exactly one result per
//   message: an action code, the voice index and note for starts and
//   releases, and the cutoff in hertz for control change 2.
//   m_valid rises when the voice table loads the result register from the
//   request queue, which the decoder writes at the accepting edge; a held
//   result not yet taken delays the load. Throughput is one message per cycle
//   unless the receiver stalls, set by the parallel note compare of all voices.
//   Reset frees every voice and empties the queue; no clearing pass is needed.
//   When the receiver stalls, the result register holds its request and the
//   queue keeps taking messages until its two entries fill, then s_ready
//   drops.
module midi_voice_allocator #(
    parameter int VOICES = mva_pkg::VOICES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_status_byte,
    input  logic [6:0]  s_note_number,
    input  logic [6:0]  s_velocity,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_action,
    output logic [4:0]  m_voice_index,
    output logic [6:0]  m_voice_note,
    output logic [13:0] m_cutoff_hz
);
    import mva_pkg::*;

    req_t push_req, pop_req;
    logic q_push, q_pop, q_empty, q_full;

    mva_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_status_byte (s_status_byte),
        .s_note_number (s_note_number),
        .s_velocity    (s_velocity),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_req         (push_req)
    );

    mva_fifo #(
        .WIDTH ($bits(req_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (push_req),
        .pop     (q_pop),
        .rd_data (pop_req),
        .empty   (q_empty),
        .full    (q_full)
    );

    mva_back #(
        .VOICES (VOICES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_req         (pop_req),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_action      (m_action),
        .m_voice_index (m_voice_index),
        .m_voice_note  (m_voice_note),
        .m_cutoff_hz   (m_cutoff_hz)
    );

endmodule

// ----- tb/midi_voice_allocator_tb.sv -----
// Self-checking testbench for the MIDI voice allocator, with a scoreboard class and random traffic.
module midi_voice_allocator_tb;
    import mva_pkg::*;

    localparam int NUM_VOICES   = VOICES_DEFAULT;
    localparam int IDLE_PCT     = 14;
    localparam int PHASE_ITEMS  = 490;
    localparam int MAX_PRINTED  = 50;

    typedef struct packed {
        logic [2:0]  action;
        logic [4:0]  voice_index;
        logic [6:0]  voice_note;
        logic [13:0] cutoff_hz;
    } voice_result_t;

    // Tracks the voice table as the block should see it and holds the results still owed.
    class voice_scoreboard;
        logic [6:0]    held_note[NUM_VOICES];
        bit            sounding[NUM_VOICES];
        voice_result_t owed_results[$];
        int            errors;
        int            act_seen[8];

        function new();
            for (int i = 0; i < NUM_VOICES; i++) begin
                held_note[i] = 7'd0;
                sounding[i]  = 1'b0;
            end
            errors = 0;
            foreach (act_seen[i]) act_seen[i] = 0;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return owed_results.size();
        endfunction

        // Applies one accepted request to the voice table and queues what it must produce.
        function void note_request(logic [7:0] status, logic [6:0] note, logic [6:0] vel);
            voice_result_t res;
            logic [7:0]    kind;
            int            hit;
            int            slot;
            res  = '0;
            kind = status & MSG_TYPE_MASK;
            hit  = -1;
            slot = -1;
            for (int i = NUM_VOICES - 1; i >= 0; i--) begin
                if (sounding[i] && held_note[i] == note) hit = i;
                if (!sounding[i]) slot = i;
            end
            if (kind == MSG_NOTE_ON && vel != 7'd0) begin
                if (hit >= 0) begin
                    res.action = ACT_PLAYING;
                end else if (slot < 0) begin
                    res.action = ACT_NO_VOICE;
                end else begin
                    sounding[slot]  = 1'b1;
                    held_note[slot] = note;
                    res.action      = ACT_START;
                    res.voice_index = 5'(slot);
                    res.voice_note  = note;
                end
            end else if (kind == MSG_NOTE_ON || kind == MSG_NOTE_OFF) begin
                // A Note On with zero velocity is treated as a Note Off.
                if (hit >= 0) begin
                    sounding[hit]   = 1'b0;
                    res.action      = ACT_RELEASE;
                    res.voice_index = 5'(hit);
                    res.voice_note  = note;
                end else begin
                    res.action = ACT_IGNORED;
                end
            end else if (kind == MSG_CTRL && note == CTRL_CUTOFF) begin
                res.action    = ACT_CUTOFF;
                res.cutoff_hz = 14'(CUTOFF_BASE + (int'(vel) * CUTOFF_SPAN) / CTRL_MAX);
            end else begin
                res.action = ACT_IGNORED;
            end
            act_seen[res.action]++;
            owed_results.push_back(res);
        endfunction

        task check_result(logic [2:0] action, logic [4:0] idx, logic [6:0] note,
                          logic [13:0] hz);
            voice_result_t want;
            if (owed_results.size() == 0) begin
                report($sformatf("result action=%0d with no request pending", action));
            end else begin
                want = owed_results.pop_front();
                if (action !== want.action)
                    report($sformatf("action %0d, expected %0d", action, want.action));
                if (idx !== want.voice_index)
                    report($sformatf("voice_index %0d, expected %0d", idx, want.voice_index));
                if (note !== want.voice_note)
                    report($sformatf("voice_note %0d, expected %0d", note, want.voice_note));
                if (hz !== want.cutoff_hz)
                    report($sformatf("cutoff_hz %0d, expected %0d", hz, want.cutoff_hz));
            end
        endtask
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_status_byte = 8'd0;
    logic [6:0]  s_note_number = 7'd0;
    logic [6:0]  s_velocity    = 7'd0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [2:0]  m_action;
    logic [4:0]  m_voice_index;
    logic [6:0]  m_voice_note;
    logic [13:0] m_cutoff_hz;

    bit              calm = 1'b0;
    voice_scoreboard sb   = new();

    midi_voice_allocator u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_status_byte (s_status_byte),
        .s_note_number (s_note_number),
        .s_velocity    (s_velocity),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_action      (m_action),
        .m_voice_index (m_voice_index),
        .m_voice_note  (m_voice_note),
        .m_cutoff_hz   (m_cutoff_hz)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Requests are noted before results are checked so the queue order follows acceptance.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_request(s_status_byte, s_note_number, s_velocity);
            if (m_valid && m_ready)
                sb.check_result(m_action, m_voice_index, m_voice_note, m_cutoff_hz);
        end
    end

    // Optionally idles, then presents one request and holds it until it is accepted.
    task push_msg(logic [7:0] status, logic [6:0] note, logic [6:0] vel);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_status_byte <= status;
        s_note_number <= note;
        s_velocity    <= vel;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Mostly well-formed note traffic around a small pool of notes so voices fill and free.
    task run_notes(int target);
        int         done;
        int         pick;
        int         pool_base;
        logic [3:0] chan;
        logic [7:0] status;
        logic [6:0] note;
        logic [6:0] vel;
        done      = 0;
        pool_base = $urandom_range(0, 116);
        while (done < target) begin
            pick = $urandom_range(0, 99);
            chan = 4'($urandom_range(0, 15));
            note = ($urandom_range(0, 99) < 75) ? 7'(pool_base + $urandom_range(0, 11))
                                                : 7'($urandom_range(0, 127));
            vel  = 7'($urandom_range(0, 127));
            if (pick < 45) begin
                status = MSG_NOTE_ON | {4'd0, chan};
                vel    = ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
            end else if (pick < 75) begin
                status = MSG_NOTE_OFF | {4'd0, chan};
            end else if (pick < 85) begin
                status = MSG_CTRL | {4'd0, chan};
                if ($urandom_range(0, 3) != 0) note = CTRL_CUTOFF;
            end else begin
                status = 8'($urandom_range(0, 255));
            end
            push_msg(status, note, vel);
            done++;
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Extremes, lowest-free allocation and the already-sounding case.
        push_msg(MSG_NOTE_ON, 7'd0, 7'd127);
        push_msg(8'h9F, 7'd127, 7'd1);
        push_msg(8'h93, 7'd0, 7'd64);
        for (int n = 10; n < 16; n++) push_msg(MSG_NOTE_ON, 7'(n), 7'd100);
        // Every voice is busy now.
        push_msg(MSG_NOTE_ON, 7'd20, 7'd90);
        push_msg(8'h8F, 7'd127, 7'd127);
        push_msg(MSG_NOTE_ON, 7'd0, 7'd0);
        push_msg(MSG_NOTE_OFF, 7'd99, 7'd0);
        push_msg(MSG_NOTE_ON, 7'd50, 7'd1);
        // Cutoff at both ends and in the middle, then other controllers.
        push_msg(MSG_CTRL, CTRL_CUTOFF, 7'd0);
        push_msg(8'hBA, CTRL_CUTOFF, 7'd127);
        push_msg(MSG_CTRL, CTRL_CUTOFF, 7'd64);
        push_msg(MSG_CTRL, 7'd3, 7'd127);
        push_msg(MSG_CTRL, 7'd127, 7'd5);
        // Message types the block does not handle.
        push_msg(8'h00, 7'd12, 7'd127);
        push_msg(8'hA0, 7'd10, 7'd30);
        push_msg(8'hC5, 7'd11, 7'd0);
        push_msg(8'hE0, 7'd127, 7'd127);
        push_msg(8'hFF, 7'd127, 7'd127);

        for (int phase = 0; phase < 4; phase++) begin
            calm <= (phase == 1);
            run_notes(PHASE_ITEMS);
            // Hold off the sender until the block has drained.
            s_valid <= 1'b0;
            do @(posedge aclk); while (sb.pending() != 0);
        end

        calm    <= 1'b0;
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.pending() != 0) sb.report("results still owed at end of run");

        $display("Covered %0d starts, %0d releases, %0d cutoffs, %0d no-free-voice,",
                 sb.act_seen[ACT_START], sb.act_seen[ACT_RELEASE],
                 sb.act_seen[ACT_CUTOFF], sb.act_seen[ACT_NO_VOICE]);
        $display("%0d already-playing and %0d ignored messages under random stalls.",
                 sb.act_seen[ACT_PLAYING], sb.act_seen[ACT_IGNORED]);
        if (sb.errors == 0) begin
            $display("midi_voice_allocator test passed");
        end else begin
            $display("midi_voice_allocator test failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("midi_voice_allocator test failed");
        $finish;
    end

endmodule

// ----- midi_voice_allocator.f -----
rtl/mva_pkg.sv
rtl/mva_front.sv
rtl/mva_fifo.sv
rtl/mva_back.sv
rtl/midi_voice_allocator.sv
tb/midi_voice_allocator_tb.sv
